### hdl/cfh_pkg.sv
// Shared types and constants for the cylinder flux histogram.
package cfh_pkg;

  localparam int CoordBits = 32;
  localparam int FluxBits  = 56;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_ADD     = 2'd1,
    OP_READ    = 2'd2,
    OP_SUMMARY = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_MODE   = 3'd0,
    CFG_RADIUS = 3'd1,
    CFG_AXIAL  = 3'd2,
    CFG_FLUX   = 3'd3,
    CFG_POWER  = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [5:0]  cell_column;
    logic [5:0]  cell_row;
  } in_item_t;

  typedef struct packed {
    logic        in_range;
    logic [23:0] cell_count;
    logic [55:0] cell_flux;
    logic [31:0] total_hits;
    logic [23:0] peak_count;
    logic [55:0] peak_flux;
    logic [55:0] target_power;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture item, set up vector
    logic cordic_step;
    logic bin;        // compute column, row, address
    logic mem_read;
    logic update;     // write back count, totals
    logic clr_step;   // clear one cell
    logic clr_first;  // reset clear counter and totals
    logic prod_a;     // first product pass
    logic prod_b;     // second product pass
    logic emit;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] op;
    logic       cordic_done;
    logic       clr_done;
  } sts_t;

  // CORDIC angle table, turns in Q0.32.
  function automatic logic [31:0] turn_entry(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0: t = 32'h20000000;  5'd1: t = 32'h12E4051E;
      5'd2: t = 32'h09FB385B;  5'd3: t = 32'h051111D4;
      5'd4: t = 32'h028B0D43;  5'd5: t = 32'h0145D7E1;
      5'd6: t = 32'h00A2F61E;  5'd7: t = 32'h00517C55;
      5'd8: t = 32'h0028BE53;  5'd9: t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2FA; 5'd15: t = 32'h0000517D;
      5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518;
      5'd20: t = 32'h0000028C; 5'd21: t = 32'h00000146;
      5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A; 5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
      5'd30: t = 32'h00000001; default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

### hdl/cylinder_flux_histogram.sv
// Top level of the cylinder flux histogram.
// One item per start; an add hit runs the CORDIC at one rotation a cycle (a zero vector skips
// the rotations), then bins, reads and updates its cell; read and summary items skip the CORDIC.
// Clear sweeps the full memory (COLUMNS and ROWS each rounded up to a power of two), one cell a cycle.
// A result strobes for one cycle at the end; the receiver cannot stall it.
// Synchronous reset restores config and totals, then busy holds while every cell is zeroed.
module cylinder_flux_histogram
  import cfh_pkg::*;
#(
  parameter int COLUMNS      = 64,
  parameter int ROWS         = 64,
  parameter int COUNT_BITS   = 24,
  parameter int CORDIC_STEPS = 20
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_strobe,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic mode_r;
  logic [30:0] radius_r;
  logic [31:0] axial_r, flux_r;
  logic [23:0] power_r;

  assign cfg_ready = 1'b1;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      radius_r <= 31'd36700;
      axial_r <= 32'd419430;
      flux_r <= 32'd65536;
      power_r <= 24'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:   mode_r <= cfg_data[0];
        CFG_RADIUS: radius_r <= cfg_data[30:0];
        CFG_AXIAL:  axial_r <= cfg_data;
        CFG_FLUX:   flux_r <= cfg_data;
        CFG_POWER:  power_r <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  cfh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .busy(busy), .cmd(cmd)
  );

  cfh_datapath #(
    .COLUMNS(COLUMNS), .ROWS(ROWS), .COUNT_BITS(COUNT_BITS), .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd),
    .geometry_mode(mode_r), .tube_radius(radius_r), .axial_bin_scale(axial_r),
    .flux_scale(flux_r), .power_scale(power_r),
    .sts(sts), .out_data(out_data), .out_strobe(out_strobe)
  );

endmodule

### hdl/cfh_ctrl.sv
// Controller state machine for the cylinder flux histogram.
module cfh_ctrl
  import cfh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output logic busy,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_CORDIC, S_BIN, S_READ, S_UPDATE,
    S_CLEAR, S_PROD_A, S_PROD_B, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // Sequence one item through the datapath.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      // Sweep every cell to zero after reset.
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_CLEAR: begin
            cmd.clr_first = 1'b1;
            state_nxt = S_CLEAR;
          end
          OP_ADD:   state_nxt = S_CORDIC;
          OP_READ: begin
            cmd.mem_read = 1'b1;
            state_nxt = S_READ;
          end
          default:  state_nxt = S_PROD_A;
        endcase
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (sts.cordic_done) state_nxt = S_BIN;
      end
      S_BIN: begin
        cmd.bin = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        if (sts.op == OP_ADD) cmd.mem_read = 1'b1;
        state_nxt = (sts.op == OP_ADD) ? S_UPDATE : S_PROD_A;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt = S_PROD_A;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_PROD_A;
      end
      S_PROD_A: begin
        cmd.prod_a = 1'b1;
        state_nxt = S_PROD_B;
      end
      S_PROD_B: begin
        cmd.prod_b = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### hdl/cfh_datapath.sv
// Datapath: CORDIC angle, binning, cell memory, totals and products.
module cfh_datapath
  import cfh_pkg::*;
#(
  parameter int COLUMNS      = 64,
  parameter int ROWS         = 64,
  parameter int COUNT_BITS   = 24,
  parameter int CORDIC_STEPS = 20
)(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  input  logic      geometry_mode,
  input  logic [30:0] tube_radius,
  input  logic [31:0] axial_bin_scale,
  input  logic [31:0] flux_scale,
  input  logic [23:0] power_scale,
  output sts_t      sts,
  output out_item_t out_data,
  output logic      out_strobe
);

  localparam int ColBits  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RowBits  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AddrBits = ColBits + RowBits;
  localparam int Cells    = 1 << AddrBits;
  localparam int StepBits = $clog2(CORDIC_STEPS + 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  in_item_t item_r;
  logic signed [34:0] vx_r, vy_r;
  logic signed [33:0] ang_r;
  logic [StepBits-1:0] step_r;
  logic [AddrBits-1:0] addr_r, clr_addr_r;
  logic hit_ok_r;
  logic [COUNT_BITS-1:0] mem [Cells];
  logic [COUNT_BITS-1:0] rd_r, cnt_r;
  logic [31:0] total_r;
  logic [COUNT_BITS-1:0] peak_r;
  logic inr_r;
  logic [55:0] cflux_r, pflux_r, power_r;
  logic strobe_r;

  // Set up the CORDIC vector with the half-turn pre-rotation.
  logic signed [34:0] a_w, b_w;
  always_comb begin
    a_w = 35'(in_data.coord_x);
    b_w = geometry_mode ? (35'(in_data.coord_z) - 35'($signed({1'b0, tube_radius})))
                        : 35'(in_data.coord_y);
  end

  // One CORDIC rotation per cycle.
  logic signed [34:0] xs_w, ys_w;
  logic [4:0] sidx_w;
  always_comb begin
    sidx_w = 5'(step_r);
    xs_w = vx_r >>> sidx_w;
    ys_w = vy_r >>> sidx_w;
  end

  // Bin the angle and axial position.
  logic signed [39:0] col_w;
  logic signed [63:0] axial_w;
  logic signed [96:0] rowp_w;
  logic signed [60:0] row_w;
  always_comb begin
    col_w = 40'(ang_r) * 40'(COLUMNS);
    col_w = (col_w >>> 32) + 40'(COLUMNS / 2);
    axial_w = geometry_mode ? 64'(item_r.coord_y) : 64'(item_r.coord_z);
    rowp_w = 97'(axial_w) * $signed({65'd0, axial_bin_scale});
    row_w = 61'(rowp_w >>> 36);
    if (geometry_mode) row_w = row_w + 61'(ROWS / 2);
  end

  // Cell memory, single write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.update && hit_ok_r) begin
      mem[addr_r] <= (rd_r == CountMax) ? rd_r : rd_r + 1'b1;
    end
    if (cmd.mem_read) rd_r <= mem[addr_r];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      peak_r <= '0;
      strobe_r <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      strobe_r <= cmd.emit;
      if (cmd.load) begin
        item_r <= in_data;
        inr_r <= 1'b0;
        cnt_r <= '0;
        hit_ok_r <= 1'b0;
        addr_r <= {ColBits'(in_data.cell_column), RowBits'(in_data.cell_row)};
        if (a_w == 0 && b_w == 0) begin
          vx_r <= '0; vy_r <= '0; ang_r <= '0;
          step_r <= StepBits'(CORDIC_STEPS);
        end else if (b_w < 0) begin
          vx_r <= -b_w; vy_r <= -a_w;
          ang_r <= (a_w >= 0) ? 34'sd2147483648 : -34'sd2147483648;
          step_r <= '0;
        end else begin
          vx_r <= b_w; vy_r <= a_w; ang_r <= '0;
          step_r <= '0;
        end
      end
      if (cmd.mem_read && item_r.opcode == OP_READ) begin
        inr_r <= (32'(item_r.cell_column) < COLUMNS) && (32'(item_r.cell_row) < ROWS);
      end
      if (cmd.cordic_step && step_r < StepBits'(CORDIC_STEPS)) begin
        step_r <= step_r + 1'b1;
        if (vy_r >= 0) begin
          vx_r <= vx_r + ys_w; vy_r <= vy_r - xs_w;
          ang_r <= ang_r + 34'(turn_entry(sidx_w));
        end else begin
          vx_r <= vx_r - ys_w; vy_r <= vy_r + xs_w;
          ang_r <= ang_r - 34'(turn_entry(sidx_w));
        end
      end
      if (cmd.bin) begin
        hit_ok_r <= (col_w >= 0) && (col_w < 40'(COLUMNS)) &&
                    (row_w >= 0) && (row_w < 61'(ROWS));
        addr_r <= {ColBits'(col_w), RowBits'(row_w)};
      end
      if (cmd.update && hit_ok_r) begin
        cnt_r <= (rd_r == CountMax) ? rd_r : rd_r + 1'b1;
        inr_r <= 1'b1;
        if (total_r != '1) total_r <= total_r + 1'b1;
        if (((rd_r == CountMax) ? rd_r : rd_r + 1'b1) > peak_r)
          peak_r <= (rd_r == CountMax) ? rd_r : rd_r + 1'b1;
      end
      if (cmd.clr_first) begin
        clr_addr_r <= '0;
        total_r <= '0;
        peak_r <= '0;
      end
      if (cmd.clr_step) clr_addr_r <= clr_addr_r + 1'b1;
      // Read-cell count is taken from the registered read in the first product pass.
      if (cmd.prod_a && item_r.opcode == OP_READ) cnt_r <= inr_r ? rd_r : '0;
      if (cmd.prod_b) begin
        cflux_r <= 56'(64'(cnt_r) * 64'(flux_scale));
        pflux_r <= 56'(64'(peak_r) * 64'(flux_scale));
        power_r <= 56'(64'(total_r) * 64'(power_scale));
      end
    end
  end

  assign sts.op = item_r.opcode;
  assign sts.cordic_done = (step_r >= StepBits'(CORDIC_STEPS - 1)) ||
                           (step_r == StepBits'(CORDIC_STEPS));
  assign sts.clr_done = (clr_addr_r == AddrBits'(Cells - 1));

  // Drive the result.
  always_comb begin
    out_data.in_range     = inr_r;
    out_data.cell_count   = 24'(cnt_r);
    out_data.cell_flux    = cflux_r;
    out_data.total_hits   = total_r;
    out_data.peak_count   = 24'(peak_r);
    out_data.peak_flux    = pflux_r;
    out_data.target_power = power_r;
  end
  assign out_strobe = strobe_r;

  // Peak never trails a fresh count; total saturates instead of wrapping.
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.update) && $past(hit_ok_r) |-> peak_r >= cnt_r) else $error("peak low");
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    $past(total_r) == 32'hFFFFFFFF && !$past(cmd.clr_first) |-> total_r == 32'hFFFFFFFF)
    else $error("total wrapped");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("strobe held");

endmodule
